@@ hdl/dda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

  localparam int ScreenWidth  = 1920;
  localparam int ScreenHeight = 1080;
  localparam int CoordW       = 20;
  localparam int PosW         = 40;
  localparam int StepW        = 20;
  localparam int ChW          = 26;
  localparam int QuoW         = 33;
  localparam int DivW         = 48;
  localparam int QDepth       = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [1:0] REG_STRIDE     = 2'd1;
  localparam logic [1:0] REG_BPP        = 2'd2;

  localparam logic signed [ChW-1:0] ChMax = {1'b0, {(ChW-1){1'b1}}};
  localparam logic signed [ChW-1:0] ChMin = {1'b1, {(ChW-1){1'b0}}};

  // One classified command passed from front to back.
  typedef struct packed {
    logic                     is_load;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic [7:0]               s_r;
    logic [7:0]               s_g;
    logic [7:0]               s_b;
    logic [7:0]               e_r;
    logic [7:0]               e_g;
    logic [7:0]               e_b;
  } cmd_t;

  // One emitted pixel.
  typedef struct packed {
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [23:0]        color;
    logic [31:0]        addr;
    logic               vis;
    logic               last;
  } pix_t;

  function automatic logic [7:0] chan_byte(input logic signed [ChW-1:0] c);
    logic [7:0] r;
    if (c < 0) r = 8'd0;
    else if (c[ChW-2:16] > 9'd255) r = 8'd255;
    else r = c[23:16];
    return r;
  endfunction

  function automatic logic signed [ChW:0] ext_ch(input logic signed [ChW-1:0] c);
    return {c[ChW-1], c};
  endfunction

endpackage
`default_nettype wire

@@ hdl/dda_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dda_cmd_fifo
  import dda_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);
  cmd_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(QDepth));
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rp_q];

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= push_data_i;
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule
`default_nettype wire

@@ hdl/dda_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dda_divider
  import dda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DivW-1:0]   num_i,
  input  wire logic [CoordW:0]   den_i,
  output logic                   done_o,
  output logic [DivW-1:0]        quo_o
);
  // Restoring divider, one quotient bit per cycle.
  logic [DivW-1:0] quo_q;
  logic [CoordW+1:0] rem_q;
  logic [CoordW:0]   den_q;
  logic [5:0]        cnt_q;
  logic              busy_q;
  logic [CoordW+1:0] sh;
  logic [CoordW+1:0] df;

  always_comb begin
    sh = {rem_q[CoordW:0], quo_q[DivW-1]};
    df = sh - {1'b0, den_q};
  end

  assign quo_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!df[CoordW+1]) begin
        rem_q <= df;
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/dda_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dda_engine
  import dda_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] frame_base_i,
  input  wire logic [15:0] line_stride_i,
  input  wire logic [2:0]  bpp_i,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_empty_i,
  output logic             cmd_pop_o,
  output pix_t             pix_o,
  output logic             pix_valid_o,
  input  wire logic        pix_stall_i
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_WAIT, S_DONE, S_ADDR} state_e;
  state_e state_q;

  logic                     active_q;
  logic signed [PosW-1:0]   pos_q  [2];
  logic signed [PosW-1:0]   end_q  [2];
  logic signed [StepW-1:0]  pstep_q[2];
  logic signed [ChW-1:0]    ch_q   [3];
  logic signed [ChW-1:0]    cstep_q[3];

  logic signed [8:0]        cdelta_q[3];
  logic signed [CoordW:0]   dx_q, dy_q;
  logic [CoordW:0]          len_q;
  logic [2:0]               div_idx_q;
  logic                     div_neg_q;
  logic                     div_start;
  logic [DivW-1:0]          div_num;
  logic                     div_done;
  logic [DivW-1:0]          div_quo;

  // Pixel stage registers for the address pipeline.
  logic signed [12:0]       rx_q, ry_q;
  logic                     rvis_q, rlast_q;
  logic [23:0]              rcol_q;
  logic                     out_full_q;

  function automatic logic signed [PosW-1:0] rnd(input logic signed [PosW-1:0] p);
    logic [PosW-1:0] a;
    logic [PosW-1:0] r;
    a = p[PosW-1] ? -p : p;
    r = (a + 40'd32768) >> 16;
    return p[PosW-1] ? -r : r;
  endfunction

  function automatic logic [PosW:0] mag(input logic signed [PosW:0] v);
    return v[PosW] ? -v : v;
  endfunction

  // Continue check on given state.
  function automatic logic cont(input logic signed [PosW-1:0] p0, input logic signed [PosW-1:0] p1,
                                input logic signed [PosW-1:0] e0, input logic signed [PosW-1:0] e1,
                                input logic signed [StepW-1:0] s0, input logic signed [StepW-1:0] s1);
    logic signed [PosW:0] d0, d1, t0, t1;
    d0 = {e0[PosW-1], e0} - {p0[PosW-1], p0};
    d1 = {e1[PosW-1], e1} - {p1[PosW-1], p1};
    t0 = (PosW+1)'(s0);
    t1 = (PosW+1)'(s1);
    return (mag(d0) >= mag(t0)) && (mag(d1) >= mag(t1));
  endfunction

  logic signed [CoordW:0] adx, ady;
  logic signed [CoordW:0] div_sig;
  logic [DivW-1:0]        div_mag;
  logic signed [DivW-1:0] q_signed;
  logic signed [PosW-1:0] np[2];
  logic signed [ChW:0]    nc[3];
  logic signed [ChW-1:0]  ncs[3];
  logic signed [12:0]     fx, fy;
  logic                   fvis;
  logic                   step_go;
  logic                   step_emit;
  logic                   emit_go;

  always_comb begin
    adx = dx_q[CoordW] ? -dx_q : dx_q;
    ady = dy_q[CoordW] ? -dy_q : dy_q;
    case (div_idx_q)
      3'd0:    div_sig = dx_q;
      3'd1:    div_sig = dy_q;
      3'd2:    div_sig = (CoordW+1)'(cdelta_q[0]);
      3'd3:    div_sig = (CoordW+1)'(cdelta_q[1]);
      default: div_sig = (CoordW+1)'(cdelta_q[2]);
    endcase
    div_mag = DivW'(div_sig[CoordW] ? -div_sig : div_sig);
    if (div_idx_q < 3'd2) div_num = div_mag << 16;
    else                  div_num = div_mag << 24;
    q_signed = div_neg_q ? -div_quo : div_quo;
    for (int i = 0; i < 2; i++) np[i] = pos_q[i] + PosW'(pstep_q[i]);
    for (int i = 0; i < 3; i++) begin
      nc[i]  = ext_ch(ch_q[i]) + ext_ch(cstep_q[i]);
      ncs[i] = (nc[i] > ext_ch(ChMax)) ? ChMax :
               (nc[i] < ext_ch(ChMin)) ? ChMin : nc[i][ChW-1:0];
    end
    fx = 13'(rnd(pos_q[0]));
    fy = 13'(rnd(pos_q[1]));
    fvis = !fx[12] && (fx < 13'(ScreenWidth)) && !fy[12] && (fy < 13'(ScreenHeight));
    emit_go = !out_full_q || !pix_valid_o || !pix_stall_i;
    step_go = (state_q == S_IDLE) && !cmd_empty_i && !cmd_i.is_load && emit_go;
    step_emit = step_go && active_q;
    cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i && (cmd_i.is_load || !active_q || emit_go);
    div_start = (state_q == S_DIV);
  end

  dda_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(len_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Sequence loads through the divider and step the accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      active_q   <= 1'b0;
      out_full_q <= 1'b0;
      pix_valid_o <= 1'b0;
      div_idx_q  <= '0;
      for (int i = 0; i < 2; i++) begin
        pos_q[i] <= '0; end_q[i] <= '0; pstep_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        ch_q[i] <= '0; cstep_q[i] <= '0;
      end
    end else begin
      // Address stage: hold until the output register frees.
      if (out_full_q && (!pix_valid_o || !pix_stall_i)) begin
        pix_valid_o <= 1'b1;
        pix_o.px    <= rx_q[11:0];
        pix_o.py    <= ry_q[11:0];
        pix_o.color <= rcol_q;
        pix_o.vis   <= rvis_q;
        pix_o.last  <= rlast_q;
        pix_o.addr  <= rvis_q ? frame_base_i + 32'(ry_q[10:0]) * 32'(line_stride_i)
                               + 32'(rx_q[10:0]) * 32'(bpp_i) : 32'd0;
      end else if (pix_valid_o && !pix_stall_i) begin
        pix_valid_o <= 1'b0;
      end
      out_full_q <= step_emit || (out_full_q && pix_valid_o && pix_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o && cmd_i.is_load) begin
            active_q <= 1'b0;
            dx_q <= (CoordW+1)'(cmd_i.end_x) - (CoordW+1)'(cmd_i.start_x);
            dy_q <= (CoordW+1)'(cmd_i.end_y) - (CoordW+1)'(cmd_i.start_y);
            pos_q[0] <= PosW'(cmd_i.start_x) <<< 8;
            pos_q[1] <= PosW'(cmd_i.start_y) <<< 8;
            end_q[0] <= PosW'(cmd_i.end_x) <<< 8;
            end_q[1] <= PosW'(cmd_i.end_y) <<< 8;
            ch_q[0] <= ChW'({cmd_i.s_r, 16'd0});
            ch_q[1] <= ChW'({cmd_i.s_g, 16'd0});
            ch_q[2] <= ChW'({cmd_i.s_b, 16'd0});
            cdelta_q[0] <= 9'(cmd_i.e_r) - 9'(cmd_i.s_r);
            cdelta_q[1] <= 9'(cmd_i.e_g) - 9'(cmd_i.s_g);
            cdelta_q[2] <= 9'(cmd_i.e_b) - 9'(cmd_i.s_b);
            div_idx_q <= 3'd0;
            state_q <= S_ADDR;
          end else if (step_emit) begin
            rx_q   <= fx;
            ry_q   <= fy;
            rvis_q <= fvis;
            rcol_q <= {chan_byte(ch_q[0]), chan_byte(ch_q[1]), chan_byte(ch_q[2])};
            rlast_q <= !cont(np[0], np[1], end_q[0], end_q[1], pstep_q[0], pstep_q[1]);
            active_q <= cont(np[0], np[1], end_q[0], end_q[1], pstep_q[0], pstep_q[1]);
            for (int i = 0; i < 2; i++) pos_q[i] <= np[i];
            for (int i = 0; i < 3; i++) ch_q[i] <= ncs[i];
          end
        end
        S_ADDR: begin
          // Form the major-axis length; drop a zero-length line.
          len_q <= (adx > ady) ? adx : ady;
          if (adx == 0 && ady == 0) state_q <= S_IDLE;
          else state_q <= S_DIV;
        end
        S_DIV: begin
          div_neg_q <= div_sig[CoordW];
          state_q   <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            case (div_idx_q)
              3'd0: pstep_q[0] <= StepW'(q_signed);
              3'd1: pstep_q[1] <= StepW'(q_signed);
              default: cstep_q[2'(div_idx_q - 3'd2)] <=
                (q_signed > DivW'(ChMax)) ? ChMax :
                (q_signed < DivW'(ChMin)) ? ChMin : ChW'(q_signed);
            endcase
            if (div_idx_q == 3'd4) state_q <= S_DONE;
            else begin
              div_idx_q <= div_idx_q + 3'd1;
              state_q   <= S_DIV;
            end
          end
        end
        S_DONE: begin
          active_q <= cont(pos_q[0], pos_q[1], end_q[0], end_q[1], pstep_q[0], pstep_q[1]);
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/dda_line_rasterizer_color_lerp.sv @@
// Line rasterizer with color interpolation.
// Step items: one pixel per cycle while the output does not stall, through
// the command queue, step stage and address stage registers.
// Load items: five steps are found in turn by the shared bit-serial divider.
// Reset (async, active low) clears the queue and the line state and returns
// the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module dda_line_rasterizer_color_lerp
  import dda_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic signed [19:0] start_x_i,
  input  wire logic signed [19:0] start_y_i,
  input  wire logic signed [19:0] end_x_i,
  input  wire logic signed [19:0] end_y_i,
  input  wire logic [7:0]         start_red_i,
  input  wire logic [7:0]         start_green_i,
  input  wire logic [7:0]         start_blue_i,
  input  wire logic [7:0]         end_red_i,
  input  wire logic [7:0]         end_green_i,
  input  wire logic [7:0]         end_blue_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [11:0]      pixel_x_o,
  output logic signed [11:0]      pixel_y_o,
  output logic [23:0]             pixel_color_o,
  output logic [31:0]             pixel_address_o,
  output logic                    on_screen_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  logic [31:0] frame_base_q;
  logic [15:0] stride_q;
  logic [2:0]  bpp_q;
  cmd_t        push_cmd, pop_cmd;
  logic        full, empty, pop;
  pix_t        pix;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
      stride_q     <= 16'd7680;
      bpp_q        <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_BASE: frame_base_q <= cfg_data_i;
        REG_STRIDE:     stride_q     <= cfg_data_i[15:0];
        REG_BPP:        bpp_q        <= cfg_data_i[2:0];
        default:        ;
      endcase
    end
  end

  // Classify the beat into a command.
  always_comb begin
    push_cmd.is_load = (op_i == OP_LOAD);
    push_cmd.start_x = start_x_i;
    push_cmd.start_y = start_y_i;
    push_cmd.end_x   = end_x_i;
    push_cmd.end_y   = end_y_i;
    push_cmd.s_r     = start_red_i;
    push_cmd.s_g     = start_green_i;
    push_cmd.s_b     = start_blue_i;
    push_cmd.e_r     = end_red_i;
    push_cmd.e_g     = end_green_i;
    push_cmd.e_b     = end_blue_i;
  end

  dda_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(in_valid_i), .push_data_i(push_cmd), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_cmd), .empty_o(empty)
  );

  dda_engine u_eng (
    .clk_i, .rst_ni, .frame_base_i(frame_base_q), .line_stride_i(stride_q),
    .bpp_i(bpp_q), .cmd_i(pop_cmd), .cmd_empty_i(empty), .cmd_pop_o(pop),
    .pix_o(pix), .pix_valid_o(out_valid_o), .pix_stall_i(out_stall_i)
  );

  assign pixel_x_o       = pix.px;
  assign pixel_y_o       = pix.py;
  assign pixel_color_o   = pix.color;
  assign pixel_address_o = pix.addr;
  assign on_screen_o     = pix.vis;
  assign last_o          = pix.last;
endmodule
`default_nettype wire
